// ===== rtl/core/csr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package csr_pkg;
    localparam int CANVAS_COLS_DEF = 64;
    localparam int CANVAS_ROWS_DEF = 32;
    localparam int CW = 12;
    localparam int AW = 16;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_PIXEL = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_RECT  = 3'd3;
    localparam logic [2:0] OP_CIRC  = 3'd4;
    localparam logic [2:0] OP_TRI   = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;

    localparam logic signed [AW-1:0] CIRC_D0  = 16'sd3;
    localparam logic signed [AW-1:0] CIRC_K10 = 16'sd10;
    localparam logic signed [AW-1:0] CIRC_K6  = 16'sd6;
endpackage
`default_nettype wire

// ===== rtl/core/clipped_shape_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// group  | dir | tdata, low bit up                                      | tuser
// s_axis | in  | ax ay bx by cx cy radius (12 each) glyph[7:0] color[2:0] | opcode[2:0]
// m_axis | out | read_glyph[7:0] read_color[2:0]                         | read_valid
// A command is accepted while idle, runs its body, then holds its result until m_tready.
// Body: clear fills every cell, pixel writes one point, rectangle walks its edges (none if
// empty), line walks its line, triangle its three lines, circle its octants, read the store.
// Reset clears only the sequencer; the frame store is undefined until a clear.
// s_tready is high only while idle, so a result held by m_tready holds the input.
module clipped_shape_rasterizer
    import csr_pkg::*;
#(
    parameter int CANVAS_COLS = CANVAS_COLS_DEF,
    parameter int CANVAS_ROWS = CANVAS_ROWS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata, // ax ay bx by cx cy radius glyph color
    input  wire logic [2:0]  s_tuser, // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata, // read_glyph read_color
    output logic             m_tuser  // read_valid
);
    localparam int CELLS = CANVAS_COLS * CANVAS_ROWS;
    localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_LSET = 4'd2, S_LRUN = 4'd3,
        S_RECT = 4'd4, S_CSTEP = 4'd5, S_CPLOT = 4'd6, S_RD1 = 4'd7, S_RD2 = 4'd8,
        S_OUT = 4'd9;

    logic [3:0] st_reg;
    logic [2:0] op_reg;
    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, rad_reg;
    logic [7:0] g_reg;
    logic [2:0] c_reg;
    logic signed [AW-1:0] x_reg, y_reg, x1_reg, y1_reg, dx_reg, dy_reg, err_reg;
    logic signed [AW-1:0] u_reg, v_reg, d_reg, i_reg;
    logic [2:0] sub_reg;
    logic [1:0] seg_reg;
    logic [IW-1:0] clr_reg;
    logic [7:0] gmem [CELLS];
    logic [2:0] cmem [CELLS];
    logic [7:0] rg_reg;
    logic [2:0] rc_reg;
    logic rv_reg;
    logic [15:0] out_reg;

    logic signed [AW-1:0] px, py;
    logic pwe, ponc;
    logic [IW-1:0] paddr;

    logic signed [AW-1:0] e2, ldx, ldy;
    logic xstep, ystep;

    logic signed [AW-1:0] rlim, rinc, rni;
    logic rwrap, rect_none;
    logic [2:0] rsub;

    assign rect_none = (bx_reg <= 0) || (by_reg <= 0);
    assign rlim = sub_reg[1] ? AW'(by_reg) : AW'(bx_reg);
    assign rinc = i_reg + AW'(1);
    assign rwrap = (rinc == rlim);
    assign rni = rwrap ? AW'(0) : rinc;
    assign rsub = rwrap ? sub_reg + 3'd1 : sub_reg;

    always_comb begin
        px = x_reg;
        py = y_reg;
        if (st_reg == S_CPLOT) begin
            case (sub_reg)
                3'd0: begin px = AW'(ax_reg) + u_reg; py = AW'(ay_reg) + v_reg; end
                3'd1: begin px = AW'(ax_reg) - u_reg; py = AW'(ay_reg) + v_reg; end
                3'd2: begin px = AW'(ax_reg) + u_reg; py = AW'(ay_reg) - v_reg; end
                3'd3: begin px = AW'(ax_reg) - u_reg; py = AW'(ay_reg) - v_reg; end
                3'd4: begin px = AW'(ax_reg) + v_reg; py = AW'(ay_reg) + u_reg; end
                3'd5: begin px = AW'(ax_reg) - v_reg; py = AW'(ay_reg) + u_reg; end
                3'd6: begin px = AW'(ax_reg) + v_reg; py = AW'(ay_reg) - u_reg; end
                default: begin px = AW'(ax_reg) - v_reg; py = AW'(ay_reg) - u_reg; end
            endcase
        end
        ponc = (px >= 0) && (px < CANVAS_COLS) && (py >= 0) && (py < CANVAS_ROWS);
        paddr = IW'(py * CANVAS_COLS + px);
        pwe = ponc && (st_reg == S_LRUN || st_reg == S_CPLOT
                       || (st_reg == S_RECT && (op_reg == OP_PIXEL || !rect_none)));
    end

    assign e2 = err_reg <<< 1;
    assign ldx = (x1_reg > x_reg) ? x1_reg - x_reg : x_reg - x1_reg;
    assign ldy = (y1_reg > y_reg) ? y1_reg - y_reg : y_reg - y1_reg;
    assign xstep = e2 > -dy_reg;
    assign ystep = e2 < dx_reg;

    always_ff @(posedge aclk) begin
        if (st_reg == S_CLR) begin
            gmem[clr_reg] <= g_reg;
            cmem[clr_reg] <= 3'd0;
        end else if (pwe) begin
            gmem[paddr] <= g_reg;
            cmem[paddr] <= c_reg;
        end
        rg_reg <= gmem[paddr];
        rc_reg <= cmem[paddr];
    end

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = (st_reg == S_OUT);
    assign m_tdata = out_reg;
    assign m_tuser = rv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            case (st_reg)
                S_IDLE: if (s_tvalid) begin
                    case (s_tuser)
                        OP_CLEAR: st_reg <= S_CLR;
                        OP_PIXEL, OP_RECT: st_reg <= S_RECT;
                        OP_LINE, OP_TRI: st_reg <= S_LSET;
                        OP_CIRC: st_reg <= S_CSTEP;
                        OP_READ: st_reg <= S_RD1;
                        default: st_reg <= S_OUT;
                    endcase
                    op_reg <= s_tuser;
                    ax_reg <= s_tdata[11:0];  ay_reg <= s_tdata[23:12];
                    bx_reg <= s_tdata[35:24]; by_reg <= s_tdata[47:36];
                    rad_reg <= s_tdata[83:72];
                    g_reg <= s_tdata[91:84];  c_reg <= s_tdata[94:92];
                    out_reg <= '0;
                    rv_reg <= 1'b0;
                    clr_reg <= '0;
                    seg_reg <= 2'd0;
                    i_reg <= '0;
                    sub_reg <= 3'd0;
                    u_reg <= '0;
                    v_reg <= AW'(signed'(s_tdata[83:72]));
                    d_reg <= CIRC_D0 - (AW'(signed'(s_tdata[83:72])) <<< 1);
                    if (s_tuser == OP_TRI) begin
                        x_reg <= AW'(signed'(s_tdata[35:24]));
                        y_reg <= AW'(signed'(s_tdata[47:36]));
                        x1_reg <= AW'(signed'(s_tdata[59:48]));
                        y1_reg <= AW'(signed'(s_tdata[71:60]));
                    end else begin
                        x_reg <= AW'(signed'(s_tdata[11:0]));
                        y_reg <= AW'(signed'(s_tdata[23:12]));
                        x1_reg <= AW'(signed'(s_tdata[35:24]));
                        y1_reg <= AW'(signed'(s_tdata[47:36]));
                    end
                end
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IW'(CELLS - 1)) st_reg <= S_OUT;
                end
                S_LSET: begin
                    dx_reg <= ldx; dy_reg <= ldy; err_reg <= ldx - ldy;
                    st_reg <= S_LRUN;
                end
                S_LRUN: begin
                    if (x_reg == x1_reg && y_reg == y1_reg) begin
                        if (op_reg == OP_TRI && seg_reg != 2'd2) begin
                            seg_reg <= seg_reg + 2'd1;
                            x_reg <= x1_reg; y_reg <= y1_reg;
                            x1_reg <= (seg_reg == 2'd0) ? AW'(ax_reg) : AW'(bx_reg);
                            y1_reg <= (seg_reg == 2'd0) ? AW'(ay_reg) : AW'(by_reg);
                            st_reg <= S_LSET;
                        end else st_reg <= S_OUT;
                    end else begin
                        err_reg <= err_reg - (xstep ? dy_reg : AW'(0))
                                           + (ystep ? dx_reg : AW'(0));
                        if (xstep)
                            x_reg <= (x1_reg > x_reg) ? x_reg + AW'(1) : x_reg - AW'(1);
                        if (ystep)
                            y_reg <= (y1_reg > y_reg) ? y_reg + AW'(1) : y_reg - AW'(1);
                    end
                end
                S_RECT: begin
                    if (op_reg == OP_PIXEL || rect_none) begin
                        st_reg <= S_OUT;
                    end else begin
                        if (rwrap && sub_reg == 3'd3) st_reg <= S_OUT;
                        else if (rwrap) sub_reg <= sub_reg + 3'd1;
                        i_reg <= rni;
                        case (rsub)
                            3'd0: begin
                                x_reg <= AW'(ax_reg) + rni;
                                y_reg <= AW'(ay_reg);
                            end
                            3'd1: begin
                                x_reg <= AW'(ax_reg) + rni;
                                y_reg <= AW'(ay_reg) + AW'(by_reg) - AW'(1);
                            end
                            3'd2: begin
                                x_reg <= AW'(ax_reg);
                                y_reg <= AW'(ay_reg) + rni;
                            end
                            default: begin
                                x_reg <= AW'(ax_reg) + AW'(bx_reg) - AW'(1);
                                y_reg <= AW'(ay_reg) + rni;
                            end
                        endcase
                    end
                end
                S_CSTEP: begin
                    if (rad_reg < 0) st_reg <= S_OUT;
                    else if (rad_reg == 0) begin
                        x_reg <= AW'(ax_reg); y_reg <= AW'(ay_reg);
                        op_reg <= OP_PIXEL;
                        st_reg <= S_RECT;
                    end else st_reg <= S_CPLOT;
                end
                S_CPLOT: begin
                    sub_reg <= sub_reg + 3'd1;
                    if (sub_reg == 3'd7) begin
                        if (!(v_reg >= u_reg)) st_reg <= S_OUT;
                        else begin
                            u_reg <= u_reg + AW'(1);
                            if (d_reg > 0) begin
                                v_reg <= v_reg - AW'(1);
                                d_reg <= d_reg + ((u_reg + AW'(1) - (v_reg - AW'(1))) <<< 2)
                                         + CIRC_K10;
                            end else begin
                                d_reg <= d_reg + ((u_reg + AW'(1)) <<< 2) + CIRC_K6;
                            end
                        end
                    end
                end
                S_RD1: st_reg <= S_RD2;
                S_RD2: begin
                    out_reg <= ponc ? {5'd0, rc_reg, rg_reg} : 16'd0;
                    rv_reg <= ponc;
                    st_reg <= S_OUT;
                end
                S_OUT: if (m_tready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while held");
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted twice");
`endif
endmodule
`default_nettype wire

// ===== sim/clipped_shape_rasterizer_test.sv =====
`timescale 1ns / 1ps
module clipped_shape_rasterizer_test
    import csr_pkg::*;
();

    localparam int COLS = CANVAS_COLS_DEF;
    localparam int ROWS = CANVAS_ROWS_DEF;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]         op;
        logic signed [11:0] ax, ay, bx, by, cx, cy, radius;
        logic [7:0]         glyph;
        logic [2:0]         color;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] glyph;
        logic [2:0] color;
        logic       valid;
    } read_res_t;

    typedef struct {
        draw_cmd_t cmd;
        bit        typed;
        read_res_t res;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic         m_tuser;

    logic [7:0] glyph_mem [COLS*ROWS];
    logic [2:0] color_mem [COLS*ROWS];
    read_res_t  pending_reads [$];
    int         mismatches;
    int         burst_left;

    clipped_shape_rasterizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic void put_pix(int x, int y, logic [7:0] g, logic [2:0] c);
        if (x >= 0 && x < COLS && y >= 0 && y < ROWS) begin
            glyph_mem[y*COLS + x] = g;
            color_mem[y*COLS + x] = c;
        end
    endfunction

    function automatic void walk_line(int x0, int y0, int x1, int y1,
                                      logic [7:0] g, logic [2:0] c);
        int dx, dy, stx, sty, err, e2;
        dx = x1 > x0 ? x1 - x0 : x0 - x1;
        dy = y1 > y0 ? y1 - y0 : y0 - y1;
        stx = x0 < x1 ? 1 : -1;
        sty = y0 < y1 ? 1 : -1;
        err = dx - dy;
        forever begin
            put_pix(x0, y0, g, c);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x0 += stx;
            end
            if (e2 < dx) begin
                err += dx;
                y0 += sty;
            end
        end
    endfunction

    function automatic void draw_octants(int xm, int ym, int u, int v,
                                         logic [7:0] g, logic [2:0] c);
        put_pix(xm + u, ym + v, g, c);
        put_pix(xm - u, ym + v, g, c);
        put_pix(xm + u, ym - v, g, c);
        put_pix(xm - u, ym - v, g, c);
        put_pix(xm + v, ym + u, g, c);
        put_pix(xm - v, ym + u, g, c);
        put_pix(xm + v, ym - u, g, c);
        put_pix(xm - v, ym - u, g, c);
    endfunction

    function automatic void walk_ring(int xm, int ym, int r, logic [7:0] g, logic [2:0] c);
        int u, v, d;
        u = 0;
        v = r;
        if (r < 0) return;
        if (r == 0) begin
            put_pix(xm, ym, g, c);
            return;
        end
        d = 3 - 2 * r;
        draw_octants(xm, ym, u, v, g, c);
        while (v >= u) begin
            u++;
            if (d > 0) begin
                v--;
                d += 4 * (u - v) + 10;
            end else begin
                d += 4 * u + 6;
            end
            draw_octants(xm, ym, u, v, g, c);
        end
    endfunction

    function automatic void draw_rect(int x, int y, int w, int h, logic [7:0] g, logic [2:0] c);
        if (w <= 0 || h <= 0) return;
        for (int i = 0; i < w; i++) begin
            put_pix(x + i, y, g, c);
            put_pix(x + i, y + h - 1, g, c);
        end
        for (int i = 0; i < h; i++) begin
            put_pix(x, y + i, g, c);
            put_pix(x + w - 1, y + i, g, c);
        end
    endfunction

    function automatic read_res_t apply_cmd(draw_cmd_t k);
        read_res_t r;
        int ax, ay, bx, by, cx, cy;
        r = '{8'd0, 3'd0, 1'b0};
        ax = int'(k.ax);
        ay = int'(k.ay);
        bx = int'(k.bx);
        by = int'(k.by);
        cx = int'(k.cx);
        cy = int'(k.cy);
        case (k.op)
            OP_CLEAR: begin
                for (int i = 0; i < COLS*ROWS; i++) begin
                    glyph_mem[i] = k.glyph;
                    color_mem[i] = 3'd0;
                end
            end
            OP_PIXEL: put_pix(ax, ay, k.glyph, k.color);
            OP_LINE:  walk_line(ax, ay, bx, by, k.glyph, k.color);
            OP_RECT:  draw_rect(ax, ay, bx, by, k.glyph, k.color);
            OP_CIRC:  walk_ring(ax, ay, int'(k.radius), k.glyph, k.color);
            OP_TRI: begin
                walk_line(bx, by, cx, cy, k.glyph, k.color);
                walk_line(cx, cy, ax, ay, k.glyph, k.color);
                walk_line(ax, ay, bx, by, k.glyph, k.color);
            end
            OP_READ: begin
                if (ax >= 0 && ax < COLS && ay >= 0 && ay < ROWS) begin
                    r.glyph = glyph_mem[ay*COLS + ax];
                    r.color = color_mem[ay*COLS + ax];
                    r.valid = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic draw_cmd_t mk(logic [2:0] op, int ax, int ay, int bx, int by,
                                     int cx, int cy, int rad, int g, int c);
        draw_cmd_t k;
        k.op = op;
        k.ax = ax[11:0];
        k.ay = ay[11:0];
        k.bx = bx[11:0];
        k.by = by[11:0];
        k.cx = cx[11:0];
        k.cy = cy[11:0];
        k.radius = rad[11:0];
        k.glyph = g[7:0];
        k.color = c[2:0];
        return k;
    endfunction

    function automatic int near_coord();
        if ($urandom_range(0, 99) < 4) return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 80)) - 8;
    endfunction

    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t k;
        int pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 3) op = OP_CLEAR;
        else if (pick < 18) op = OP_PIXEL;
        else if (pick < 36) op = OP_LINE;
        else if (pick < 51) op = OP_RECT;
        else if (pick < 64) op = OP_CIRC;
        else if (pick < 76) op = OP_TRI;
        else if (pick < 98) op = OP_READ;
        else op = OP_UNUSED;
        k = mk(op, near_coord(), near_coord(), near_coord(), near_coord(),
               near_coord(), near_coord(), 0, $urandom_range(0, 255), $urandom_range(0, 7));
        if (op == OP_RECT && $urandom_range(0, 3) != 0) begin
            k.bx = 12'(int'($urandom_range(0, 24)) - 3);
            k.by = 12'(int'($urandom_range(0, 16)) - 3);
        end
        if ($urandom_range(0, 99) < 2) k.radius = 12'($urandom);
        else k.radius = 12'(int'($urandom_range(0, 26)) - 4);
        return k;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_cmd(draw_cmd_t k, bit typed, read_res_t want);
        int gap;
        read_res_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, k.color, k.glyph, k.radius, k.cy, k.cx, k.by, k.bx,
                     k.ay, k.ax};
        s_tuser  <= k.op;
        do @(posedge aclk); while (!s_tready);
        r = apply_cmd(k);
        pending_reads.push_back(typed ? want : r);
        burst_left--;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                report("unexpected transaction", m_tdata, 16'd0);
            end else begin
                read_res_t w;
                w = pending_reads.pop_front();
                if (m_tdata[7:0] !== w.glyph)
                    report("read_glyph", 16'(m_tdata[7:0]), 16'(w.glyph));
                if (m_tdata[10:8] !== w.color)
                    report("read_color", 16'(m_tdata[10:8]), 16'(w.color));
                if (m_tuser !== w.valid)
                    report("read_valid", 16'(m_tuser), 16'(w.valid));
            end
        end
    end

    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 96 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_cnt % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    initial begin
        #500_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        dir_row_t rows [$];
        read_res_t none;
        none = '{8'd0, 3'd0, 1'b0};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        burst_left = 0;

        rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 8'h2E, 5), 1, none});
        rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{8'h2E, 3'd0, 1'b1}});
        rows.push_back('{mk(OP_READ, 63, 31, 0, 0, 0, 0, 0, 0, 0), 1, '{8'h2E, 3'd0, 1'b1}});
        rows.push_back('{mk(OP_READ, 64, 0, 0, 0, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{mk(OP_READ, -1, -2048, 0, 0, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{mk(OP_READ, 0, 32, 0, 0, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{mk(OP_PIXEL, 2047, 2047, 0, 0, 0, 0, 0, 255, 7), 1, none});
        rows.push_back('{mk(OP_PIXEL, -2048, -2048, 0, 0, 0, 0, 0, 255, 7), 1, none});
        rows.push_back('{mk(OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 255, 7), 1, none});
        rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{8'hFF, 3'd7, 1'b1}});
        rows.push_back('{mk(OP_LINE, 0, 0, 63, 31, 0, 0, 0, 8'h41, 1), 0, none});
        rows.push_back('{mk(OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 8'h42, 2), 0, none});
        rows.push_back('{mk(OP_RECT, 5, 5, 10, 4, 0, 0, 0, 8'h43, 3), 0, none});
        rows.push_back('{mk(OP_RECT, 2, 2, 0, 5, 0, 0, 0, 8'h44, 4), 0, none});
        rows.push_back('{mk(OP_RECT, 2, 2, 5, -1, 0, 0, 0, 8'h45, 5), 0, none});
        rows.push_back('{mk(OP_CIRC, 32, 16, 0, 0, 0, 0, 10, 8'h46, 6), 0, none});
        rows.push_back('{mk(OP_CIRC, 10, 10, 0, 0, 0, 0, 0, 8'h47, 7), 0, none});
        rows.push_back('{mk(OP_CIRC, 20, 20, 0, 0, 0, 0, -1, 8'h48, 1), 0, none});
        rows.push_back('{mk(OP_TRI, 40, 30, 3, 2, 60, 8, 0, 8'h49, 2), 0, none});
        rows.push_back('{mk(OP_UNUSED, 1, 1, 0, 0, 0, 0, 0, 8'h4A, 3), 1, none});
        rows.push_back('{mk(OP_READ, 32, 6, 0, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(OP_READ, 2, 2, 0, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(OP_READ, 20, 20, 0, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0), 1, none});
        rows.push_back('{mk(OP_READ, 10, 10, 0, 0, 0, 0, 0, 0, 0), 1, '{8'h00, 3'd0, 1'b1}});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);

        for (int n = 0; n < 1000; n++) begin
            if (n == 500) begin
                s_tvalid <= 1'b0;
                while (pending_reads.size() != 0) @(posedge aclk);
                burst_left = 0;
            end
            send_cmd(rand_cmd(), 0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
